// ----- sv/addressed_packet_deframer_defines.svh -----
// Assertion helpers shared by the deframer RTL.
`ifndef ADDRESSED_PACKET_DEFRAMER_DEFINES_SVH
`define ADDRESSED_PACKET_DEFRAMER_DEFINES_SVH

// Checked only while out of reset.
`define APD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define APD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/apd_pkg.sv -----
package apd_pkg;

    typedef enum logic [5:0] {
        PH_HEADER   = 6'b000001,
        PH_ADDRESS  = 6'b000010,
        PH_ID       = 6'b000100,
        PH_LENGTH   = 6'b001000,
        PH_PAYLOAD  = 6'b010000,
        PH_CHECKSUM = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_BYTE    = 3'd1,
        EV_GOOD    = 3'd2,
        EV_BADSUM  = 3'd3,
        EV_ADDR    = 3'd4,
        EV_LEN     = 3'd5,
        EV_TIMEOUT = 3'd6
    } event_t;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_START_CODE     = 2'd1;
    localparam logic [1:0] REG_BUFFER_LIMIT   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd3;

    localparam logic [31:0] RST_DEVICE_ADDRESS = 32'hFFFF_FFFF;
    localparam logic [15:0] RST_START_CODE     = 16'hEF01;
    localparam logic [8:0]  RST_BUFFER_LIMIT   = 9'd256;
    localparam logic [19:0] RST_TIMEOUT_TICKS  = 20'd1000;

    localparam logic [19:0] IDLE_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [31:0] device_address;
        logic [15:0] start_code;
        logic [8:0]  buffer_limit;
        logic [19:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  data_byte;
        logic [7:0]  packet_id;
        logic [8:0]  payload_length;
    } res_t;

endpackage

// ----- sv/apd_core.sv -----
module apd_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          opcode,
    input  logic [7:0]    rx_byte,
    input  apd_pkg::cfg_t cfg,
    output apd_pkg::res_t res
);

    localparam int BLW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] LEN_CAP = 17'(MAX_PAYLOAD + 2);

    apd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]    window_reg, window_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic [31:0]    addr_reg, addr_next;
    logic [7:0]     id_reg, id_next;
    logic [7:0]     len_hi_reg, len_hi_next;
    logic [8:0]     plen_reg, plen_next;
    logic [BLW-1:0] left_reg, left_next;
    logic [15:0]    sum_reg, sum_next;
    logic [7:0]     sum_hi_reg, sum_hi_next;
    logic [19:0]    idle_reg, idle_next;

    logic [15:0] len_full;
    logic [15:0] len_minus2;
    logic [16:0] buf_cap;
    logic [31:0] addr_shift;
    logic [15:0] window_shift;
    logic [19:0] idle_inc;
    logic        len_bad;

    assign len_full     = {len_hi_reg, rx_byte};
    assign len_minus2   = len_full - 16'd2;
    assign buf_cap      = {8'd0, cfg.buffer_limit} + 17'd2;
    assign addr_shift   = {addr_reg[23:0], rx_byte};
    assign window_shift = {window_reg[7:0], rx_byte};
    assign idle_inc     = (idle_reg < apd_pkg::IDLE_MAX) ? idle_reg + 20'd1 : idle_reg;
    assign len_bad      = (len_full < 16'd2) || ({1'b0, len_full} > LEN_CAP)
                          || ({1'b0, len_full} > buf_cap);

    always_comb begin
        phase_next  = phase_reg;
        window_next = window_reg;
        cnt_next    = cnt_reg;
        addr_next   = addr_reg;
        id_next     = id_reg;
        len_hi_next = len_hi_reg;
        plen_next   = plen_reg;
        left_next   = left_reg;
        sum_next    = sum_reg;
        sum_hi_next = sum_hi_reg;
        idle_next   = idle_reg;
        res.event_res      = apd_pkg::EV_NONE;
        res.data_byte      = 8'd0;
        res.payload_length = 9'd0;

        if (opcode) begin
            if (phase_reg != apd_pkg::PH_HEADER) begin
                idle_next = idle_inc;
                if (idle_inc >= cfg.timeout_ticks) begin
                    res.event_res = apd_pkg::EV_TIMEOUT;
                    idle_next     = 20'd0;
                    phase_next    = apd_pkg::PH_HEADER;
                    window_next   = 16'd0;
                    cnt_next      = 2'd0;
                end
            end
        end else begin
            idle_next = 20'd0;
            unique case (phase_reg)
                apd_pkg::PH_HEADER: begin
                    window_next = window_shift;
                    if (window_shift == cfg.start_code) begin
                        phase_next  = apd_pkg::PH_ADDRESS;
                        window_next = 16'd0;
                        cnt_next    = 2'd0;
                    end
                end
                apd_pkg::PH_ADDRESS: begin
                    addr_next = addr_shift;
                    cnt_next  = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        if (addr_shift != cfg.device_address) begin
                            res.event_res = apd_pkg::EV_ADDR;
                            phase_next    = apd_pkg::PH_HEADER;
                            window_next   = 16'd0;
                        end else begin
                            phase_next = apd_pkg::PH_ID;
                        end
                    end
                end
                apd_pkg::PH_ID: begin
                    id_next    = rx_byte;
                    sum_next   = {8'd0, rx_byte};
                    cnt_next   = 2'd0;
                    phase_next = apd_pkg::PH_LENGTH;
                end
                apd_pkg::PH_LENGTH: begin
                    if (cnt_reg == 2'd0) begin
                        len_hi_next = rx_byte;
                        cnt_next    = 2'd1;
                    end else begin
                        cnt_next = 2'd0;
                        if (len_bad) begin
                            res.event_res = apd_pkg::EV_LEN;
                            phase_next    = apd_pkg::PH_HEADER;
                            window_next   = 16'd0;
                        end else begin
                            sum_next   = sum_reg + {8'd0, len_hi_reg} + {8'd0, rx_byte};
                            left_next  = BLW'(len_minus2);
                            plen_next  = len_minus2[8:0];
                            phase_next = (len_minus2 != 16'd0) ? apd_pkg::PH_PAYLOAD
                                                                : apd_pkg::PH_CHECKSUM;
                        end
                    end
                end
                apd_pkg::PH_PAYLOAD: begin
                    res.event_res = apd_pkg::EV_BYTE;
                    res.data_byte = rx_byte;
                    sum_next      = sum_reg + {8'd0, rx_byte};
                    left_next     = left_reg - BLW'(1);
                    if (left_reg == BLW'(1)) begin
                        phase_next = apd_pkg::PH_CHECKSUM;
                        cnt_next   = 2'd0;
                    end
                end
                apd_pkg::PH_CHECKSUM: begin
                    if (cnt_reg == 2'd0) begin
                        sum_hi_next = rx_byte;
                        cnt_next    = 2'd1;
                    end else begin
                        if ({sum_hi_reg, rx_byte} == sum_reg) begin
                            res.event_res      = apd_pkg::EV_GOOD;
                            res.payload_length = plen_reg;
                        end else begin
                            res.event_res = apd_pkg::EV_BADSUM;
                        end
                        phase_next  = apd_pkg::PH_HEADER;
                        window_next = 16'd0;
                        cnt_next    = 2'd0;
                    end
                end
                default: begin
                    phase_next  = apd_pkg::PH_HEADER;
                    window_next = 16'd0;
                    cnt_next    = 2'd0;
                end
            endcase
        end
        res.packet_id = id_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= apd_pkg::PH_HEADER;
            window_reg <= 16'd0;
            cnt_reg    <= 2'd0;
            addr_reg   <= 32'd0;
            id_reg     <= 8'd0;
            len_hi_reg <= 8'd0;
            plen_reg   <= 9'd0;
            left_reg   <= '0;
            sum_reg    <= 16'd0;
            sum_hi_reg <= 8'd0;
            idle_reg   <= 20'd0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            cnt_reg    <= cnt_next;
            addr_reg   <= addr_next;
            id_reg     <= id_next;
            len_hi_reg <= len_hi_next;
            plen_reg   <= plen_next;
            left_reg   <= left_next;
            sum_reg    <= sum_next;
            sum_hi_reg <= sum_hi_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

// ----- sv/addressed_packet_deframer.sv -----
// Packet deframer: takes one received byte or one time tick per transaction
// and returns exactly one result per transaction, in order. Throughput is one
// transaction per clock: the parser state and the result register update in
// the same cycle, and s_tready stays high as long as the result register is
// empty or being drained, so a stalled m_tready is the only thing that slows
// the input. m_tvalid rises in the cycle after input acceptance. The four
// configuration registers are written through the cfg_* channel, which is
// always ready; write them only while no transaction is in flight.
`include "addressed_packet_deframer_defines.svh"

module addressed_packet_deframer #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [15:8] packet_id,
                                   // [24:16] payload_length, [31:25] zero
    output logic [2:0]  m_tuser,   // [2:0] event_res
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    apd_pkg::cfg_t cfg_reg;
    apd_pkg::res_t res;
    apd_pkg::res_t res_reg;
    logic          m_valid_reg;
    logic          in_fire;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= apd_pkg::RST_DEVICE_ADDRESS;
            cfg_reg.start_code     <= apd_pkg::RST_START_CODE;
            cfg_reg.buffer_limit   <= apd_pkg::RST_BUFFER_LIMIT;
            cfg_reg.timeout_ticks  <= apd_pkg::RST_TIMEOUT_TICKS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                apd_pkg::REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                apd_pkg::REG_START_CODE:     cfg_reg.start_code     <= cfg_data[15:0];
                apd_pkg::REG_BUFFER_LIMIT:   cfg_reg.buffer_limit   <= cfg_data[8:0];
                apd_pkg::REG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks  <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    apd_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .opcode  (s_tuser),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = {7'd0, res_reg.payload_length, res_reg.packet_id, res_reg.data_byte};

    `APD_ASSERT(a_result_follows, s_tvalid && s_tready |=> m_tvalid, "accepted transaction produced no result")
    `APD_ASSERT(a_tick_no_byte, s_tvalid && s_tready && s_tuser |=> m_tuser != apd_pkg::EV_BYTE, "tick produced a payload byte")
    `APD_ASSERT(a_data_only_on_byte, m_tvalid && m_tuser != apd_pkg::EV_BYTE |-> m_tdata[7:0] == 8'd0, "data byte set outside payload event")
    `APD_ASSERT(a_len_only_on_good, m_tvalid && m_tuser != apd_pkg::EV_GOOD |-> m_tdata[24:16] == 9'd0, "payload length set outside good packet")
    `APD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
